@@ rtl/escaped_frame_decoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// Escaped frame decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i; EFD_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_DECODER_CORE_ASSERT_SVH
`define ESCAPED_FRAME_DECODER_CORE_ASSERT_SVH

// property checked outside reset
`define EFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every edge, reset included
`define EFD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/efd_pkg.sv @@
// ----------------------------------------------------------------------------
// Escaped frame decoder package
// Widths, byte codes, result kinds and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

  localparam int MAX_FRAME = 256;

  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 9;
  localparam int LEN_W   = 9;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = $clog2(MAX_FRAME + 1);
  localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(256);

  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h55;
  localparam logic [BYTE_W-1:0] CODE_START = 8'h01;
  localparam logic [BYTE_W-1:0] CODE_LIT   = 8'h02;
  localparam logic [BYTE_W-1:0] CODE_END   = 8'h03;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_CSUM = 2'd2,
    KIND_OVFL = 2'd3
  } kind_e;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/efd_in_reg.sv @@
// ----------------------------------------------------------------------------
// Escaped frame decoder input register
// Holds one received byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_in_reg
  import efd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic              take_i,
  output logic                   valid_o,
  output logic [BYTE_W-1:0]      byte_o
);

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

@@ rtl/efd_decode.sv @@
// ----------------------------------------------------------------------------
// Escaped frame decoder core logic
// Unstuffing, one-byte holdback, checksum and length tracking.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escaped_frame_decoder_core_assert.svh"

module efd_decode
  import efd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              fire_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  output result_t                res_o
);

  logic [CFG_W-1:0]  max_len_q;
  logic              esc_q, esc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic              held_vld_q, held_vld_d;

  logic [LIM_W-1:0]  limit;
  logic              over;
  logic              do_store;
  logic [BYTE_W-1:0] store_val;
  logic              do_restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign limit = (LIM_W'(max_len_q) > LIM_W'(MAX_FRAME)) ? LIM_W'(MAX_FRAME)
                                                         : LIM_W'(max_len_q);
  assign over  = LIM_W'(cnt_q) >= limit;

  always_comb begin
    res_o      = '0;
    res_o.kind = KIND_DATA;
    do_store   = 1'b0;
    store_val  = byte_i;
    do_restart = 1'b0;
    esc_d      = esc_q;
    if (over) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_OVFL;
      do_restart  = 1'b1;
    end else if (esc_q) begin
      esc_d = 1'b0;
      case (byte_i)
        CODE_START: begin
          do_restart = 1'b1;
        end
        CODE_LIT: begin
          do_store  = 1'b1;
          store_val = ESC_BYTE;
        end
        CODE_END: begin
          res_o.valid = 1'b1;
          do_restart  = 1'b1;
          if (held_vld_q && (sum_q == held_q)) begin
            res_o.kind = KIND_GOOD;
            res_o.len  = LEN_W'(cnt_q);
          end else begin
            res_o.kind = KIND_CSUM;
          end
        end
        default: begin
          do_store = 1'b1;
        end
      endcase
    end else if (byte_i == ESC_BYTE) begin
      esc_d = 1'b1;
    end else begin
      do_store = 1'b1;
    end
    if (do_restart) begin
      esc_d = 1'b0;
    end
    if (do_store && held_vld_q) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_DATA;
      res_o.data  = held_q;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    if (do_restart) begin
      cnt_d      = '0;
      sum_d      = '0;
      held_d     = '0;
      held_vld_d = 1'b0;
    end else if (do_store) begin
      if (held_vld_q) begin
        sum_d = sum_q + held_q;
      end
      held_d     = store_val;
      held_vld_d = 1'b1;
      cnt_d      = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      cnt_q      <= '0;
      sum_q      <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else if (fire_i) begin
      esc_q      <= esc_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
    end
  end

  `EFD_ASSERT(a_cnt_bound, (cnt_q <= CNT_W'(MAX_FRAME)), "count above frame limit")
  `EFD_ASSERT(a_report_clears, (fire_i && res_o.valid && res_o.kind != KIND_DATA) |=> (cnt_q == '0 && !held_vld_q && !esc_q), "report did not restart collection")
  `EFD_ASSERT(a_data_needs_held, (res_o.valid && res_o.kind == KIND_DATA) |-> (held_vld_q && do_store), "data released without held byte")
  `EFD_ASSERT(a_held_has_count, held_vld_q |-> (cnt_q != '0), "held byte with zero count")

endmodule

`default_nettype wire

@@ rtl/efd_out_reg.sv @@
// ----------------------------------------------------------------------------
// Escaped frame decoder output register
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_out_reg
  import efd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire result_t           res_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [KIND_W-1:0]      out_kind_o,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic [LEN_W-1:0]       frame_length_o
);

  logic              valid_q, valid_d;
  kind_e             kind_q;
  logic [BYTE_W-1:0] data_q;
  logic [LEN_W-1:0]  len_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_i.valid;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      kind_q <= res_i.kind;
      data_q <= res_i.data;
      len_q  <= res_i.len;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_kind_o     = kind_q;
  assign out_byte_o     = data_q;
  assign frame_length_o = len_q;

endmodule

`default_nettype wire

@@ rtl/escaped_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Escaped frame decoder core
// Byte-stuffed frame deframer with additive checksum check.
// ----------------------------------------------------------------------------
// Accepts one received byte per cycle and yields at most one result per byte:
// a released payload byte, frame good with its length, checksum error or
// overflow. The last byte of a frame is the checksum and is never released.
// A byte passes the input register, then the combinational decode, and its
// result is loaded into the result register; throughput is one byte per
// clock, set by the combinational decode between those registers, and drops
// only while the result register is full and not taken. max_frame_len must
// be written through the cfg port only while no transaction is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_decoder_core
  import efd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CFG_W-1:0]  cfg_max_frame_len_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [KIND_W-1:0]      out_kind_o,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic [LEN_W-1:0]       frame_length_o
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              out_free;
  logic              fire;
  result_t           res;

  assign cfg_ready_o = 1'b1;
  assign fire        = s1_valid && out_free;

  efd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (fire),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  efd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_max_frame_len_i),
    .fire_i      (fire),
    .byte_i      (s1_byte),
    .res_o       (res)
  );

  efd_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (fire),
    .res_i          (res),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .frame_length_o (frame_length_o)
  );

endmodule

`default_nettype wire

@@ test/escaped_frame_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// Escaped frame decoder core testbench
// Sends byte-stuffed frames, noise and broken sequences under several frame
// length limits. Decoded results are predicted per accepted byte and checked
// in order against the result channel, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_decoder_core_tb;
  import efd_pkg::*;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int PHASE_ITEMS    = 25;

  typedef struct {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } decode_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_max_frame_len_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] rx_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [KIND_W-1:0] out_kind_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic [LEN_W-1:0]  frame_length_o;

  escaped_frame_decoder_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_max_frame_len_i(cfg_max_frame_len_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_kind_o         (out_kind_o),
    .out_byte_o         (out_byte_o),
    .frame_length_o     (frame_length_o)
  );

  always #6 clk_i = ~clk_i;

  logic [BYTE_W-1:0] rx_bytes_q[$];
  decode_t           decoded_q[$];
  decode_t           want;

  // Decoder mirror
  logic [CFG_W-1:0]  cur_limit = MAX_LEN_RESET;
  logic              m_esc = 1'b0;
  int                m_count = 0;
  logic [BYTE_W-1:0] m_sum = '0;
  logic [BYTE_W-1:0] m_held = '0;
  logic              m_held_v = 1'b0;

  int n_queued = 0;
  int n_in = 0;
  int n_out = 0;
  int n_cfg = 0;
  int n_errors = 0;
  int n_good = 0;
  int n_bad = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  task automatic push_decoded(input kind_e k, input logic [BYTE_W-1:0] d,
                              input logic [LEN_W-1:0] l);
    decode_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    decoded_q.push_back(r);
  endtask

  task automatic clear_frame();
    m_esc    = 1'b0;
    m_count  = 0;
    m_sum    = '0;
    m_held   = '0;
    m_held_v = 1'b0;
  endtask

  task automatic store_decoded(input logic [BYTE_W-1:0] v);
    if (m_held_v) begin
      push_decoded(KIND_DATA, m_held, '0);
      m_sum = m_sum + m_held;
    end
    m_held   = v;
    m_held_v = 1'b1;
    m_count++;
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    int lim;
    lim = (int'(cur_limit) > MAX_FRAME) ? MAX_FRAME : int'(cur_limit);
    if (m_count >= lim) begin
      push_decoded(KIND_OVFL, '0, '0);
      clear_frame();
    end else if (m_esc) begin
      m_esc = 1'b0;
      if (b == CODE_START) begin
        clear_frame();
      end else if (b == CODE_LIT) begin
        store_decoded(ESC_BYTE);
      end else if (b == CODE_END) begin
        if (m_held_v && m_sum == m_held) begin
          push_decoded(KIND_GOOD, '0, LEN_W'(m_count));
          n_good++;
        end else begin
          push_decoded(KIND_CSUM, '0, '0);
          n_bad++;
        end
        clear_frame();
      end else begin
        store_decoded(b);
      end
    end else if (b == ESC_BYTE) begin
      m_esc = 1'b1;
    end else begin
      store_decoded(b);
    end
  endtask

  // Input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(rx_byte_i);
        n_in++;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the pending transaction
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (rx_bytes_q.size() != 0 && !no_idle && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_valid_i <= 1'b0;
      end else if (rx_bytes_q.size() != 0) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= rx_bytes_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_out++;
        if (decoded_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d with none expected: kind %0d byte %02h len %0d",
                     n_out, out_kind_o, out_byte_o, frame_length_o);
        end else begin
          want = decoded_q.pop_front();
          if (out_kind_o !== want.kind || out_byte_o !== want.data ||
              frame_length_o !== want.len) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"result %0d: expected kind %0d byte %02h len %0d, ",
                        "got kind %0d byte %02h len %0d"},
                       n_out, want.kind, want.data, want.len,
                       out_kind_o, out_byte_o, frame_length_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles", idle_cycles);
      $display("[escaped_frame_decoder_core] ERROR");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return ESC_BYTE;
      1:       return 8'h00;
      2:       return 8'hFF;
      3:       return BYTE_W'($urandom_range(1, 3));
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send(input logic [BYTE_W-1:0] b);
    rx_bytes_q.push_back(b);
    n_queued++;
  endtask

  // Stuffs one payload byte, picking among the legal encodings
  task automatic send_data(input logic [BYTE_W-1:0] b);
    if (b == ESC_BYTE) begin
      send(ESC_BYTE);
      send($urandom_range(0, 1) ? CODE_LIT : ESC_BYTE);
    end else if (b > CODE_END && $urandom_range(0, 7) == 0) begin
      send(ESC_BYTE);
      send(b);
    end else begin
      send(b);
    end
  endtask

  // n_stored counts payload plus checksum
  task automatic send_frame(input int n_stored, input bit bad_sum,
                            input bit with_start, input bit with_end);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] d;
    sum = '0;
    if (with_start) begin
      send(ESC_BYTE);
      send(CODE_START);
    end
    for (int i = 0; i < n_stored - 1; i++) begin
      d = pick_byte();
      sum = sum + d;
      send_data(d);
    end
    if (n_stored > 0)
      send_data(bad_sum ? sum ^ BYTE_W'($urandom_range(1, 255)) : sum);
    if (with_end) begin
      send(ESC_BYTE);
      send(CODE_END);
    end
  endtask

  task automatic settle();
    while (rx_bytes_q.size() != 0 || n_in != n_queued || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_max_frame_len_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_limit = v;
    n_cfg++;
  endtask

  task automatic send_random(input int budget);
    int stop;
    int lim;
    int pick;
    stop = n_queued + budget;
    lim  = (int'(cur_limit) > MAX_FRAME) ? MAX_FRAME : int'(cur_limit);
    while (n_queued < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_frame($urandom_range(1, (lim < 2) ? 1 : ((lim - 1 < 12) ? lim - 1 : 12)),
                   pick == 5, 1'b1, 1'b1);
      end else if (pick == 6 && lim <= 16) begin
        send_frame(lim + $urandom_range(0, 2), 1'b0, 1'b1, 1'b1);
      end else if (pick <= 7) begin
        send_frame($urandom_range(0, 5), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 6)) send(pick_byte());
      end
    end
  endtask

  logic [CFG_W-1:0] cfg_plan[8] = '{9'd1, 9'd0, 9'd511, 9'd2, 9'd7, 9'd300, 9'd16, 9'd256};

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limit: stray bytes, empty frame, escapes and codes
    send(8'h00); send(8'hFF); send(ESC_BYTE); send(CODE_END);
    send(ESC_BYTE); send(CODE_START); send(ESC_BYTE); send(CODE_END);
    send(ESC_BYTE); send(CODE_START); send(ESC_BYTE); send(CODE_LIT);
    send(ESC_BYTE); send(8'hAA); send(ESC_BYTE); send(8'hFF);
    send(ESC_BYTE); send(CODE_END);
    send(ESC_BYTE); send(ESC_BYTE); send(CODE_START);
    send(ESC_BYTE); send(CODE_START);
    send(8'h00); send(ESC_BYTE); send(CODE_END);
    settle();

    foreach (cfg_plan[p]) begin
      if (p == $size(cfg_plan) - 1)
        no_idle = 1'b1;
      write_limit(cfg_plan[p]);
      case (cfg_plan[p])
        9'd0: begin
          repeat (12) send(pick_byte());
        end
        9'd1: begin
          // limit hit by data and by an escape
          send(ESC_BYTE); send(CODE_START); send(8'h07); send(8'h07);
          send(8'h07); send(ESC_BYTE); send(CODE_END); send(ESC_BYTE);
          send_random(PHASE_ITEMS);
        end
        9'd511: begin
          send_frame(MAX_FRAME + 1, 1'b0, 1'b1, 1'b1);
          send_random(PHASE_ITEMS);
        end
        9'd256: begin
          send_frame(150, 1'b0, 1'b1, 1'b1);
          send_random(PHASE_ITEMS);
        end
        default: send_random(PHASE_ITEMS);
      endcase
      settle();
    end

    if (decoded_q.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", decoded_q.size());
    end
    $display("%0d bytes in, %0d results checked (%0d good frames, %0d checksum errors)",
             n_in, n_out, n_good, n_bad);
    $display("%0d limit settings, %0d mismatches", n_cfg, n_errors);
    if (n_errors == 0) begin
      $display("[escaped_frame_decoder_core] OK");
    end else begin
      $display("[escaped_frame_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/efd_pkg.sv
rtl/efd_in_reg.sv
rtl/efd_decode.sv
rtl/efd_out_reg.sv
rtl/escaped_frame_decoder_core.sv
test/escaped_frame_decoder_core_tb.sv
